@@ rtl/vnia_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vnia_pkg
// Shared constants and types for the nearest instance assign block.
// ----------------------------------------------------------------------------
package vnia_pkg;

  localparam int KeySlots      = 8;
  localparam int InstanceSlots = 64;
  localparam int GridX         = 200;
  localparam int GridY         = 200;
  localparam int GridZ         = 16;
  localparam int PlaneSize     = GridY * GridZ;
  localparam int TotalVoxels   = GridX * PlaneSize;

  // plane size is 128 * 25: drop seven index bits, then divide by 25 through
  // its reciprocal, exact for every index inside the grid
  localparam int XPreShift = 7;
  localparam int XRecip    = 5243;
  localparam int XShift    = 17;

  localparam int KeyAw  = $clog2(KeySlots);
  localparam int InstAw = $clog2(InstanceSlots);
  localparam int DistW  = 23;

  typedef enum logic [1:0] {
    OP_LOAD_KEY  = 2'd0,
    OP_LOAD_INST = 2'd1,
    OP_ASSIGN    = 2'd2,
    OP_NONE      = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_PASS    = 2'd0,
    KIND_INST    = 2'd1,
    KIND_NO_INST = 2'd2
  } kind_e;

  typedef enum logic [0:0] {
    REG_KEY_COUNT  = 1'b0,
    REG_INST_COUNT = 1'b1
  } reg_e;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_SCAN = 2'd1,
    BK_DONE = 2'd2
  } back_state_e;

  // job handed from front to back through the one-entry valid/ready hand-off
  typedef struct packed {
    logic [19:0] vidx;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [3:0]  z;
    logic        key_hit;
    logic [7:0]  cls;
    logic [7:0]  label;
  } job_t;

endpackage
`default_nettype wire

@@ rtl/vnia_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vnia_front
// Accepts beats, writes the key table, splits the voxel index into x and the
// in-plane remainder and looks up the label among the keys.
// ----------------------------------------------------------------------------
module vnia_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [1:0]        operation_i,
  input  wire logic [5:0]        slot_i,
  input  wire logic [7:0]        label_i,
  input  wire logic [7:0]        mapped_class_i,
  input  wire logic [19:0]       voxel_index_i,
  input  wire logic [3:0]        key_count_i,
  output logic                   inst_we_o,
  output logic                   job_valid_o,
  input  wire logic              job_ready_i,
  output vnia_pkg::job_t         job_o
);

  logic [7:0] key_label_q [vnia_pkg::KeySlots];
  logic [7:0] key_class_q [vnia_pkg::KeySlots];

  logic        busy_q, busy_d;
  logic        hold_q, hold_d;
  logic [19:0] rem_q, rem_d;
  logic [7:0]  x_q, x_d;
  logic [19:0] vidx_q;
  logic        hit_q;
  logic [7:0]  cls_q;
  logic [7:0]  label_q;
  logic        accept;
  logic        is_assign;
  logic        key_hit;
  logic [7:0]  cls;
  logic [3:0]  nkeys;
  logic [19:0] plane_sh;
  logic [25:0] x_prod;

  assign accept    = in_valid_i && !in_stall_o;
  // instance loads wait until the back has no job, so a scan never sees them
  assign in_stall_o = busy_q || hold_q ||
                      ((operation_i == vnia_pkg::OP_LOAD_INST) && !job_ready_i);
  assign is_assign = (operation_i == vnia_pkg::OP_ASSIGN) &&
                     (voxel_index_i < 20'(vnia_pkg::TotalVoxels));
  assign inst_we_o = accept && (operation_i == vnia_pkg::OP_LOAD_INST);
  assign nkeys     = (key_count_i > 4'(vnia_pkg::KeySlots)) ?
                     4'(vnia_pkg::KeySlots) : key_count_i;
  assign plane_sh  = 20'(vnia_pkg::PlaneSize);

  // x by reciprocal multiply of the index over the plane size
  assign x_prod = 26'(voxel_index_i[19:vnia_pkg::XPreShift]) *
                  26'(vnia_pkg::XRecip);

  // key table writes
  always_ff @(posedge clk_i) begin
    if (accept && operation_i == vnia_pkg::OP_LOAD_KEY &&
        slot_i < 6'(vnia_pkg::KeySlots)) begin
      key_label_q[slot_i[vnia_pkg::KeyAw-1:0]] <= label_i;
      key_class_q[slot_i[vnia_pkg::KeyAw-1:0]] <= mapped_class_i;
    end
  end

  // first matching active key
  always_comb begin
    key_hit = 1'b0;
    cls     = '0;
    for (int k = vnia_pkg::KeySlots - 1; k >= 0; k--) begin
      if (4'(k) < nkeys && key_label_q[k] == label_i) begin
        key_hit = 1'b1;
        cls     = key_class_q[k];
      end
    end
  end

  // x on accept, remainder within the plane in the cycle after
  always_comb begin
    busy_d = busy_q;
    hold_d = hold_q;
    rem_d  = rem_q;
    x_d    = x_q;
    if (accept && is_assign) begin
      busy_d = 1'b1;
      rem_d  = voxel_index_i;
      x_d    = x_prod[vnia_pkg::XShift +: 8];
    end else if (busy_q) begin
      rem_d  = rem_q - 20'(x_q) * plane_sh;
      busy_d = 1'b0;
      hold_d = 1'b1;
    end else if (hold_q && job_ready_i) begin
      hold_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      hold_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      hold_q <= hold_d;
    end
  end

  // job payload, label held while stalled
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    x_q   <= x_d;
    if (accept && is_assign) begin
      vidx_q  <= voxel_index_i;
      hit_q   <= key_hit;
      cls_q   <= cls;
      label_q <= label_i;
    end
  end

  assign job_valid_o = hold_q;

  always_comb begin
    job_o.vidx    = vidx_q;
    job_o.x       = x_q;
    job_o.y       = rem_q[11:4];
    job_o.z       = rem_q[3:0];
    job_o.key_hit = hit_q;
    job_o.cls     = cls_q;
    job_o.label   = label_q;
  end

endmodule
`default_nettype wire

@@ rtl/vnia_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vnia_back
// Holds the instance table and scans it one entry a cycle for the nearest
// instance of the job's class.
// ----------------------------------------------------------------------------
module vnia_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              inst_we_i,
  input  wire logic [5:0]        slot_i,
  input  wire logic [9:0]        pos_x_i,
  input  wire logic [9:0]        pos_y_i,
  input  wire logic [9:0]        pos_z_i,
  input  wire logic [7:0]        object_class_i,
  input  wire logic [15:0]       object_id_i,
  input  wire logic [6:0]        instance_count_i,
  input  wire logic              job_valid_i,
  output logic                   job_ready_o,
  input  wire vnia_pkg::job_t    job_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [19:0]            out_voxel_index_o,
  output logic [15:0]            result_value_o,
  output logic [1:0]             result_kind_o
);

  localparam int IdxW = vnia_pkg::InstAw + 1;

  logic [9:0]  mx_q [vnia_pkg::InstanceSlots];
  logic [9:0]  my_q [vnia_pkg::InstanceSlots];
  logic [9:0]  mz_q [vnia_pkg::InstanceSlots];
  logic [7:0]  mc_q [vnia_pkg::InstanceSlots];
  logic [15:0] mi_q [vnia_pkg::InstanceSlots];

  vnia_pkg::back_state_e state_q, state_d;
  vnia_pkg::job_t        job_q;
  logic [IdxW-1:0]       idx_q, idx_d;
  logic [IdxW-1:0]       ninst;
  logic                  rd_v_q;
  logic [9:0]            rx_q, ry_q, rz_q;
  logic [7:0]            rc_q;
  logic [15:0]           rid_q;
  logic                  found_q;
  logic [vnia_pkg::DistW-1:0] best_q, dist_sq;
  logic [15:0]           best_id_q;
  logic [10:0]           dx, dy, dz;
  logic [10:0]           ax, ay, az;
  logic                  rd_en;
  logic                  take;

  // instance table writes
  always_ff @(posedge clk_i) begin
    if (inst_we_i) begin
      mx_q[slot_i[vnia_pkg::InstAw-1:0]] <= pos_x_i;
      my_q[slot_i[vnia_pkg::InstAw-1:0]] <= pos_y_i;
      mz_q[slot_i[vnia_pkg::InstAw-1:0]] <= pos_z_i;
      mc_q[slot_i[vnia_pkg::InstAw-1:0]] <= object_class_i;
      mi_q[slot_i[vnia_pkg::InstAw-1:0]] <= object_id_i;
    end
  end

  assign ninst = (instance_count_i > 7'(vnia_pkg::InstanceSlots)) ?
                 IdxW'(vnia_pkg::InstanceSlots) : IdxW'(instance_count_i);
  assign rd_en = (state_q == vnia_pkg::BK_SCAN) && (idx_q < ninst);
  assign job_ready_o = (state_q == vnia_pkg::BK_IDLE);

  // registered table read
  always_ff @(posedge clk_i) begin
    rx_q  <= mx_q[idx_q[vnia_pkg::InstAw-1:0]];
    ry_q  <= my_q[idx_q[vnia_pkg::InstAw-1:0]];
    rz_q  <= mz_q[idx_q[vnia_pkg::InstAw-1:0]];
    rc_q  <= mc_q[idx_q[vnia_pkg::InstAw-1:0]];
    rid_q <= mi_q[idx_q[vnia_pkg::InstAw-1:0]];
  end

  // squared distance of the entry read last cycle
  always_comb begin
    dx = {3'b000, job_q.x} - {rx_q[9], rx_q};
    dy = {3'b000, job_q.y} - {ry_q[9], ry_q};
    dz = {7'b0, job_q.z}   - {rz_q[9], rz_q};
    ax = dx[10] ? -dx : dx;
    ay = dy[10] ? -dy : dy;
    az = dz[10] ? -dz : dz;
    dist_sq = vnia_pkg::DistW'(ax) * vnia_pkg::DistW'(ax) +
              vnia_pkg::DistW'(ay) * vnia_pkg::DistW'(ay) +
              vnia_pkg::DistW'(az) * vnia_pkg::DistW'(az);
  end

  assign take = rd_v_q && (rc_q == job_q.cls) && (!found_q || dist_sq < best_q);

  // next state
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    unique case (state_q)
      vnia_pkg::BK_IDLE: begin
        if (job_valid_i) begin
          state_d = job_i.key_hit ? vnia_pkg::BK_SCAN : vnia_pkg::BK_DONE;
          idx_d   = '0;
        end
      end
      vnia_pkg::BK_SCAN: begin
        if (idx_q < ninst) idx_d = idx_q + 1'b1;
        else if (!rd_v_q) state_d = vnia_pkg::BK_DONE;
      end
      vnia_pkg::BK_DONE: begin
        if (!out_stall_i) state_d = vnia_pkg::BK_IDLE;
      end
      default: state_d = vnia_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vnia_pkg::BK_IDLE;
      rd_v_q  <= 1'b0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rd_v_q  <= rd_en;
      if (state_q == vnia_pkg::BK_IDLE) found_q <= 1'b0;
      else if (take) found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    if (state_q == vnia_pkg::BK_IDLE && job_valid_i) job_q <= job_i;
    if (take) begin
      best_q    <= dist_sq;
      best_id_q <= rid_q;
    end
  end

  // outputs
  always_comb begin
    out_valid_o       = (state_q == vnia_pkg::BK_DONE);
    out_voxel_index_o = job_q.vidx;
    if (!job_q.key_hit) begin
      result_value_o = {8'd0, job_q.label};
      result_kind_o  = vnia_pkg::KIND_PASS;
    end else if (found_q) begin
      result_value_o = best_id_q;
      result_kind_o  = vnia_pkg::KIND_INST;
    end else begin
      result_value_o = {8'd0, job_q.label};
      result_kind_o  = vnia_pkg::KIND_NO_INST;
    end
  end

endmodule
`default_nettype wire

@@ rtl/voxel_nearest_instance_assign.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// voxel_nearest_instance_assign
// Nearest instance of the mapped class for each voxel, by squared distance.
// ----------------------------------------------------------------------------
// A voxel beat passes through the front (x by reciprocal multiply on accept,
// the in-plane remainder the next cycle) and is then handed to the back, which
// scans the first instance_count table entries (at most 64) one per cycle
// through a registered read. The two parts overlap across beats through a
// one-entry job hand-off, but an instance load is stalled until the back holds
// no job. A key label with no instance of its class returns the label with
// kind two. Tables hold garbage until loaded.
module voxel_nearest_instance_assign (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  operation_i,
  input  wire logic [5:0]  slot_i,
  input  wire logic [7:0]  label_i,
  input  wire logic [7:0]  mapped_class_i,
  input  wire logic [9:0]  pos_x_i,
  input  wire logic [9:0]  pos_y_i,
  input  wire logic [9:0]  pos_z_i,
  input  wire logic [7:0]  object_class_i,
  input  wire logic [15:0] object_id_i,
  input  wire logic [19:0] voxel_index_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [19:0]      out_voxel_index_o,
  output logic [15:0]      result_value_o,
  output logic [1:0]       result_kind_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [0:0]  cfg_index_i,
  input  wire logic [6:0]  cfg_data_i
);

  logic [3:0]     key_count_q;
  logic [6:0]     inst_count_q;
  logic           inst_we;
  logic           job_valid;
  logic           job_ready;
  vnia_pkg::job_t job;

  // configuration registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_count_q  <= '0;
      inst_count_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        vnia_pkg::REG_KEY_COUNT:  key_count_q  <= cfg_data_i[3:0];
        vnia_pkg::REG_INST_COUNT: inst_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  vnia_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .slot_i         (slot_i),
    .label_i        (label_i),
    .mapped_class_i (mapped_class_i),
    .voxel_index_i  (voxel_index_i),
    .key_count_i    (key_count_q),
    .inst_we_o      (inst_we),
    .job_valid_o    (job_valid),
    .job_ready_i    (job_ready),
    .job_o          (job)
  );

  vnia_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .inst_we_i         (inst_we),
    .slot_i            (slot_i),
    .pos_x_i           (pos_x_i),
    .pos_y_i           (pos_y_i),
    .pos_z_i           (pos_z_i),
    .object_class_i    (object_class_i),
    .object_id_i       (object_id_i),
    .instance_count_i  (inst_count_q),
    .job_valid_i       (job_valid),
    .job_ready_o       (job_ready),
    .job_i             (job),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_voxel_index_o (out_voxel_index_o),
    .result_value_o    (result_value_o),
    .result_kind_o     (result_kind_o)
  );

endmodule
`default_nettype wire
